/* rtl/core/cor_pkg.sv */
// Shared types and constants for the circle octant rasteriser.
`timescale 1ns / 1ps

package cor_pkg;

   // Output coordinate width, two's complement.
   localparam int POINT_BITS = 14;

   // Number of mirrored points produced by one step.
   localparam int POINTS_PER_STEP = 8;
   localparam int IDX_BITS        = $clog2(POINTS_PER_STEP);

   // Depth of the job queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Input function codes.
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   // Job queue status seen by the front and back.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* rtl/core/cor_front.sv */
// Front end: takes words, keeps the octant walk state, queues step jobs.
`timescale 1ns / 1ps

module cor_front
   import cor_pkg::*;
#(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 11
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   input  logic                                   req_func,
   input  logic [COORD_BITS-1:0]                  req_center_x,
   input  logic [COORD_BITS-1:0]                  req_center_y,
   input  logic [RADIUS_BITS-1:0]                 req_radius,
   input  queue_status_type                       q_status,
   output logic                                   q_push,
   output logic [2*COORD_BITS+2*RADIUS_BITS:0]    q_job
);

   localparam int OFF_BITS = RADIUS_BITS + 2;
   localparam int DEC_BITS = RADIUS_BITS + 5;

   logic [COORD_BITS-1:0]      origin_x_ff, origin_x_in;
   logic [COORD_BITS-1:0]      origin_y_ff, origin_y_in;
   logic signed [OFF_BITS-1:0] offset_x_ff, offset_x_in;
   logic signed [OFF_BITS-1:0] offset_y_ff, offset_y_in;
   logic signed [DEC_BITS-1:0] decision_ff, decision_in;
   logic                       active_ff, active_in;

   logic                       take;
   logic signed [OFF_BITS-1:0] x_next, y_next;
   logic signed [DEC_BITS-1:0] dec_step;
   logic                       done;

   assign take = req_push && !q_status.full;

   // Advance of the walk; increments use the new offsets.
   always_comb begin
      x_next = offset_x_ff + OFF_BITS'(1);
      if (decision_ff < 0) begin
         y_next   = offset_y_ff;
         dec_step = decision_ff + (DEC_BITS'(x_next) <<< 2) + DEC_BITS'(6);
      end else begin
         y_next   = offset_y_ff - OFF_BITS'(1);
         dec_step = decision_ff + ((DEC_BITS'(x_next) - DEC_BITS'(y_next)) <<< 2)
                    + DEC_BITS'(10);
      end
      done = x_next > y_next;
   end

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      decision_in = decision_ff;
      active_in   = active_ff;
      q_push      = 1'b0;
      if (take) begin
         if (req_func == FUNC_START) begin
            origin_x_in = req_center_x;
            origin_y_in = req_center_y;
            offset_x_in = '0;
            offset_y_in = OFF_BITS'(req_radius);
            decision_in = DEC_BITS'(3) - (DEC_BITS'(req_radius) <<< 1);
            active_in   = 1'b1;
         end else if (active_ff) begin
            offset_x_in = x_next;
            offset_y_in = y_next;
            decision_in = dec_step;
            active_in   = !done;
            q_push      = 1'b1;
         end
      end
   end

   // Job carries the pre-advance offsets, which are never negative here.
   assign q_job = {done, origin_x_ff, origin_y_ff,
                   offset_x_ff[RADIUS_BITS-1:0], offset_y_ff[RADIUS_BITS-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         decision_ff <= '0;
         active_ff   <= 1'b0;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         offset_x_ff <= offset_x_in;
         offset_y_ff <= offset_y_in;
         decision_ff <= decision_in;
         active_ff   <= active_in;
      end
   end

endmodule

/* rtl/core/cor_queue.sv */
// Short job queue between the front and the back.
`timescale 1ns / 1ps

module cor_queue
   import cor_pkg::*;
#(
   parameter int WIDTH = 47
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   logic [WIDTH-1:0]     mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign status.full  = count_ff == QCNT_BITS'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/cor_back.sv */
// Back end: expands one step job into its eight mirrored points.
`timescale 1ns / 1ps

module cor_back
   import cor_pkg::*;
#(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 11
) (
   input  logic                                clock,
   input  logic                                reset,
   input  queue_status_type                    q_status,
   input  logic [2*COORD_BITS+2*RADIUS_BITS:0] q_job,
   output logic                                q_pop,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [POINT_BITS-1:0]        rsp_point_x,
   output logic signed [POINT_BITS-1:0]        rsp_point_y,
   output logic                                rsp_last_of_step,
   output logic                                rsp_circle_done
);

   localparam int JOB_BITS = 2*COORD_BITS + 2*RADIUS_BITS + 1;
   localparam int MAX_BITS = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
   localparam int WIDE     = ((MAX_BITS > POINT_BITS) ? MAX_BITS : POINT_BITS) + 2;

   logic [JOB_BITS-1:0]          job_ff, job_in;
   logic                         job_valid_ff, job_valid_in;
   logic [IDX_BITS-1:0]          idx_ff, idx_in;
   logic                         out_valid_ff, out_valid_in;
   logic signed [POINT_BITS-1:0] px_ff, px_in;
   logic signed [POINT_BITS-1:0] py_ff, py_in;
   logic                         last_ff, last_in;
   logic                         done_ff, done_in;

   logic                         load_out, is_last;
   logic                         j_done;
   logic [COORD_BITS-1:0]        j_cx, j_cy;
   logic [RADIUS_BITS-1:0]       j_x, j_y;
   logic [WIDE-1:0]              ox, oy, sx, sy;

   assign {j_done, j_cx, j_cy, j_x, j_y} = job_ff;

   assign is_last  = idx_ff == IDX_BITS'(POINTS_PER_STEP - 1);
   assign load_out = job_valid_ff && (!out_valid_ff || rsp_pop);
   assign q_pop    = (!job_valid_ff || (load_out && is_last)) && !q_status.empty;

   // Upper half of the step swaps the offsets; bit 0 and bit 1 pick the signs.
   always_comb begin
      ox = idx_ff[2] ? WIDE'(j_y) : WIDE'(j_x);
      oy = idx_ff[2] ? WIDE'(j_x) : WIDE'(j_y);
      sx = idx_ff[0] ? WIDE'(j_cx) - ox : WIDE'(j_cx) + ox;
      sy = idx_ff[1] ? WIDE'(j_cy) - oy : WIDE'(j_cy) + oy;
   end

   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      px_in        = px_ff;
      py_in        = py_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         px_in        = sx[POINT_BITS-1:0];
         py_in        = sy[POINT_BITS-1:0];
         last_in      = is_last;
         done_in      = is_last && j_done;
         idx_in       = idx_ff + IDX_BITS'(1);
         if (is_last) begin
            job_valid_in = 1'b0;
         end
      end
      if (q_pop) begin
         job_in       = q_job;
         job_valid_in = 1'b1;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_point_x      = px_ff;
   assign rsp_point_y      = py_ff;
   assign rsp_last_of_step = last_ff;
   assign rsp_circle_done  = done_ff;

endmodule

/* rtl/core/circle_octant_rasterizer.sv */
// Top level of the Bresenham circle rasteriser with eight-way symmetry.
`timescale 1ns / 1ps

// Circle rasteriser. A start word (func 0) loads centre and radius and gives
// no output; each step word (func 1) while a circle is running gives the
// eight mirrored points of the current octant position, oldest first, with
// last_of_step on the eighth and circle_done on the eighth point of the final
// step. Steps while idle are dropped. Every word, start or step, is taken
// only while the two-entry job queue has room; the back end drains each
// step at one point per cycle while pop is held, so the steady-state rate
// of step words is set by the single result port. Output is registered: a
// waiting point does not stop the front from taking words until the job
// queue fills, and a point per cycle flows when pop is held.
// Coordinates wrap to 14 bits, two's complement.
module circle_octant_rasterizer
   import cor_pkg::*;
#(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 11
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_func,
   input  logic [COORD_BITS-1:0]        req_center_x,
   input  logic [COORD_BITS-1:0]        req_center_y,
   input  logic [RADIUS_BITS-1:0]       req_radius,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic signed [POINT_BITS-1:0] rsp_point_x,
   output logic signed [POINT_BITS-1:0] rsp_point_y,
   output logic                         rsp_last_of_step,
   output logic                         rsp_circle_done
);

   // job word: {done, cx, cy, x, y}
   localparam int JOB_BITS = 2*COORD_BITS + 2*RADIUS_BITS + 1;

   queue_status_type    q_status;
   logic                q_push, q_pop;
   logic [JOB_BITS-1:0] q_in_job, q_out_job;

   // front stalls only on a full job queue
   assign req_full = q_status.full;

   cor_front #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_func     (req_func),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .q_status     (q_status),
      .q_push       (q_push),
      .q_job        (q_in_job)
   );

   cor_queue #(
      .WIDTH (JOB_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_job),
      .pop       (q_pop),
      .pop_data  (q_out_job),
      .status    (q_status)
   );

   cor_back #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_job            (q_out_job),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_circle_done  (rsp_circle_done)
   );

   // queue cannot be full and empty at once
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("job queue reports full and empty together");

   // a job is only queued when there is room
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("job pushed into full queue");

   // done only on the eighth point of a step
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_circle_done) |-> rsp_last_of_step)
      else $error("circle_done without last_of_step");

   // back end never pops an empty queue
   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("job popped from empty queue");

endmodule

/* tb/circle_octant_rasterizer_tb.sv */
// Self-checking testbench for the circle octant rasteriser.
`timescale 1ns / 1ps

module circle_octant_rasterizer_tb;
   import cor_pkg::*;

   localparam int CX_BITS = 12;
   localparam int R_BITS  = 11;
   localparam int D_BITS  = R_BITS + 5;   // decision term, two's compl.
   localparam int ITEMS   = 280;   // useful words (starts and running steps)
   localparam int CALM_AT = ITEMS - 40;   // no idling from here on

   // One plotted point as it leaves the block.
   typedef struct packed {
      logic signed [POINT_BITS-1:0] px;
      logic signed [POINT_BITS-1:0] py;
      logic                         is_last;
      logic                         is_done;
   } point_type;

   // One row of the directed table. Where typed is set, the expected points
   // are written in the row: count points, all at (tx,ty), done on the last.
   typedef struct packed {
      logic                  f;
      logic [CX_BITS-1:0]    cx;
      logic [CX_BITS-1:0]    cy;
      logic [R_BITS-1:0]     r;
      logic                  typed;
      logic [3:0]            tcount;
      logic [POINT_BITS-1:0] tx;
      logic [POINT_BITS-1:0] ty;
      logic                  tdone;
   } stim_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_push = 1'b0;
   logic                         req_full;
   logic                         req_func = FUNC_START;
   logic [CX_BITS-1:0]           req_center_x = '0;
   logic [CX_BITS-1:0]           req_center_y = '0;
   logic [R_BITS-1:0]            req_radius = '0;
   logic                         rsp_empty;
   logic                         rsp_pop = 1'b0;
   logic signed [POINT_BITS-1:0] rsp_point_x;
   logic signed [POINT_BITS-1:0] rsp_point_y;
   logic                         rsp_last_of_step;
   logic                         rsp_circle_done;

   // Sideband that travels with each word: typed expectations from the table.
   logic                  row_typed = 1'b0;
   logic [3:0]            row_count = '0;
   logic [POINT_BITS-1:0] row_x = '0;
   logic [POINT_BITS-1:0] row_y = '0;
   logic                  row_done = 1'b0;

   circle_octant_rasterizer #(
      .COORD_BITS  (CX_BITS),
      .RADIUS_BITS (R_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius       (req_radius),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_circle_done  (rsp_circle_done)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Circle walk shadow: centre, octant offsets, decision term, busy flag.
   // ---------------------------------------------------------------------
   logic [CX_BITS-1:0] centre_x = '0;
   logic [CX_BITS-1:0] centre_y = '0;
   logic [CX_BITS-1:0] walk_x = '0;
   logic [CX_BITS-1:0] walk_y = '0;
   logic signed [D_BITS-1:0] decision = '0;
   logic               walking = 1'b0;

   point_type fresh_pts[$];   // points of the word just taken
   point_type points_due[$];  // points still owed by the block, oldest first

   int mismatches  = 0;
   int words_used  = 0;
   int start_words = 0;
   int plot_steps  = 0;
   int circles_end = 0;
   int checked     = 0;
   bit calm        = 1'b0;

   function automatic point_type mk_point(input int px, input int py,
                                          input logic is_last, input logic is_done);
      point_type p;
      p.px      = px[POINT_BITS-1:0];   // wraps to 14 bits like the block
      p.py      = py[POINT_BITS-1:0];
      p.is_last = is_last;
      p.is_done = is_done;
      return p;
   endfunction

   // Advance the walk by one word and leave its points in fresh_pts.
   task automatic walk_circle(input logic f, input logic [CX_BITS-1:0] cx,
                              input logic [CX_BITS-1:0] cy,
                              input logic [R_BITS-1:0] r);
      int x, y, ox, oy, nx, ny, d;
      logic fin;
      fresh_pts.delete();
      if (f == FUNC_START) begin
         // new circle drops whatever was running
         centre_x = cx;
         centre_y = cy;
         walk_x   = '0;
         walk_y   = CX_BITS'(r);
         decision = D_BITS'(3 - 2 * int'(r));
         walking  = 1'b1;
         start_words++;
         words_used++;
      end else if (walking) begin
         x  = int'(walk_x);
         y  = int'(walk_y);
         ox = int'(centre_x);
         oy = int'(centre_y);
         d  = decision;
         // step x first, then pick the next y from the sign of the old term
         nx = x + 1;
         if (d < 0) begin
            ny = y;
            decision = D_BITS'(d + 4 * nx + 6);
         end else begin
            ny = y - 1;
            decision = D_BITS'(d + 4 * (nx - ny) + 10);
         end
         walk_x = CX_BITS'(nx);
         walk_y = CX_BITS'(ny);
         fin = (nx > ny);
         if (fin) begin
            walking = 1'b0;
            circles_end++;
         end
         fresh_pts = {fresh_pts, mk_point(ox + x, oy + y, 1'b0, 1'b0)};
         fresh_pts = {fresh_pts, mk_point(ox - x, oy + y, 1'b0, 1'b0)};
         fresh_pts = {fresh_pts, mk_point(ox + x, oy - y, 1'b0, 1'b0)};
         fresh_pts = {fresh_pts, mk_point(ox - x, oy - y, 1'b0, 1'b0)};
         fresh_pts = {fresh_pts, mk_point(ox + y, oy + x, 1'b0, 1'b0)};
         fresh_pts = {fresh_pts, mk_point(ox - y, oy + x, 1'b0, 1'b0)};
         fresh_pts = {fresh_pts, mk_point(ox + y, oy - x, 1'b0, 1'b0)};
         fresh_pts = {fresh_pts, mk_point(ox - y, oy - x, 1'b1, fin)};
         plot_steps++;
         words_used++;
      end
      // a step while idle is dropped: nothing owed, shadow untouched
   endtask

   // ---------------------------------------------------------------------
   // Scoreboard: check the popped point first, then book the taken word,
   // all in one block so the order within the edge never matters.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      point_type got;
      point_type want;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            got.px      = rsp_point_x;
            got.py      = rsp_point_y;
            got.is_last = rsp_last_of_step;
            got.is_done = rsp_circle_done;
            if (points_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected point x=%0d y=%0d last=%0b done=%0b",
                           $realtime, got.px, got.py, got.is_last, got.is_done);
            end else begin
               want = points_due.pop_front();
               checked++;
               if (got.px !== want.px || got.py !== want.py ||
                   got.is_last !== want.is_last || got.is_done !== want.is_done) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: point mismatch exp x=%0d y=%0d last=%0b done=%0b %s%0d %s%0d %s%0b %s%0b",
                              $realtime, want.px, want.py, want.is_last, want.is_done,
                              "got x=", got.px, "y=", got.py,
                              "last=", got.is_last, "done=", got.is_done);
               end
            end
         end
         if (req_push && !req_full) begin
            walk_circle(req_func, req_center_x, req_center_y, req_radius);
            if (row_typed) begin
               for (int k = 0; k < row_count; k++)
                  points_due = {points_due,
                                mk_point($signed(row_x), $signed(row_y),
                                         k == row_count - 1,
                                         row_done && (k == row_count - 1))};
            end else begin
               foreach (fresh_pts[k])
                  points_due = {points_due, fresh_pts[k]};
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: pop on or off in random bursts, held high once calm.
   // ---------------------------------------------------------------------
   int pop_hold = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (calm) begin
         rsp_pop <= 1'b1;
      end else if (pop_hold > 0) begin
         pop_hold = pop_hold - 1;
      end else begin
         rsp_pop  <= ($urandom_range(0, 2) != 0);
         pop_hold = $urandom_range(1, 9) - 1;
      end
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------
   function automatic stim_row_type row(input logic f, input int cx, input int cy,
                                        input int r, input logic typed, input int tcount,
                                        input int tx, input int ty, input logic tdone);
      stim_row_type s;
      s.f      = f;
      s.cx     = cx[CX_BITS-1:0];
      s.cy     = cy[CX_BITS-1:0];
      s.r      = r[R_BITS-1:0];
      s.typed  = typed;
      s.tcount = tcount[3:0];
      s.tx     = tx[POINT_BITS-1:0];
      s.ty     = ty[POINT_BITS-1:0];
      s.tdone  = tdone;
      return s;
   endfunction

   // Offer one word and hold it until taken; sometimes idle afterwards.
   task automatic send_word(input stim_row_type s);
      req_push     <= 1'b1;
      req_func     <= s.f;
      req_center_x <= s.cx;
      req_center_y <= s.cy;
      req_radius   <= s.r;
      row_typed    <= s.typed;
      row_count    <= s.tcount;
      row_x        <= s.tx;
      row_y        <= s.ty;
      row_done     <= s.tdone;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 9))
            @(posedge clock);
      end
   endtask

   // Random word, untyped.
   task automatic send_plain(input logic f, input int r);
      send_word(row(f, $urandom_range(0, 4095), $urandom_range(0, 4095), r,
                    1'b0, 0, 0, 0, 1'b0));
   endtask

   task automatic drain_points;
      req_push <= 1'b0;
      @(posedge clock);
      while (points_due.size() != 0)
         @(posedge clock);
   endtask

   stim_row_type directed[$];

   initial begin : stimulus
      int  kind, r, n;
      bit  paused;
      paused = 1'b0;

      repeat (4)
         @(posedge clock);
      reset <= 1'b0;

      // Directed table. Typed rows: results readable straight off the spec.
      // step straight after reset: idle, dropped
      directed = {directed, row(FUNC_STEP, 5, 5, 5, 1'b1, 0, 0, 0, 1'b0)};
      // zero radius at the low corner: eight copies of the centre, then done
      directed = {directed, row(FUNC_START, 0, 0, 0, 1'b1, 0, 0, 0, 1'b0)};
      directed = {directed, row(FUNC_STEP, 0, 0, 0, 1'b1, 8, 0, 0, 1'b1)};
      // circle finished: next step is dropped
      directed = {directed, row(FUNC_STEP, 4095, 4095, 2047, 1'b1, 0, 0, 0, 1'b0)};
      // zero radius at the high corner
      directed = {directed, row(FUNC_START, 4095, 4095, 0, 1'b1, 0, 0, 0, 1'b0)};
      directed = {directed, row(FUNC_STEP, 0, 0, 0, 1'b1, 8, 4095, 4095, 1'b1)};
      // largest radius at the low corner: most negative coordinates
      directed = {directed, row(FUNC_START, 0, 0, 2047, 1'b1, 0, 0, 0, 1'b0)};
      directed = {directed, row(FUNC_STEP, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0)};
      directed = {directed, row(FUNC_STEP, 4095, 4095, 2047, 1'b0, 0, 0, 0, 1'b0)};
      // largest radius at the high corner: most positive coordinates;
      // start over a running circle as well
      directed = {directed, row(FUNC_START, 4095, 4095, 2047, 1'b1, 0, 0, 0, 1'b0)};
      directed = {directed, row(FUNC_STEP, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0)};
      directed = {directed, row(FUNC_STEP, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0)};
      // restart while busy, radius 2 runs out in two steps
      directed = {directed, row(FUNC_START, 2048, 2048, 2, 1'b1, 0, 0, 0, 1'b0)};
      directed = {directed, row(FUNC_STEP, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0)};
      directed = {directed, row(FUNC_STEP, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0)};
      directed = {directed, row(FUNC_STEP, 0, 0, 0, 1'b1, 0, 0, 0, 1'b0)};
      // radius 1: one step, then the walk ends
      directed = {directed, row(FUNC_START, 100, 200, 1, 1'b1, 0, 0, 0, 1'b0)};
      directed = {directed, row(FUNC_STEP, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0)};
      // a small circle walked to the end, both decision branches
      directed = {directed, row(FUNC_START, 1234, 3000, 5, 1'b1, 0, 0, 0, 1'b0)};
      for (int k = 0; k < 5; k++)
         directed = {directed, row(FUNC_STEP, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0)};

      foreach (directed[k])
         send_word(directed[k]);

      // let everything owed come out before the random part
      drain_points();

      while (words_used < ITEMS) begin
         if (!paused && words_used >= ITEMS / 2) begin
            // hold off mid-run until the block has delivered every point
            paused = 1'b1;
            drain_points();
         end
         calm = (words_used >= CALM_AT);
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            // whole circle, walked past its end by up to a few steps
            r = $urandom_range(0, 24);
            send_plain(FUNC_START, r);
            n = r - r / 4 + 2 + $urandom_range(0, 2);
            repeat (n)
               send_plain(FUNC_STEP, $urandom_range(0, 2047));
         end else if (kind < 8) begin
            // broken circle: a few steps, then the next start drops it
            if ($urandom_range(0, 1))
               r = $urandom_range(0, 2047);
            else
               r = $urandom_range(0, 40);
            send_plain(FUNC_START, r);
            n = $urandom_range(0, (r / 2 < 12) ? r / 2 : 12);
            repeat (n)
               send_plain(FUNC_STEP, $urandom_range(0, 2047));
         end else begin
            // noise: any function, any fields
            repeat ($urandom_range(1, 4))
               send_plain(1'($urandom_range(0, 1)), $urandom_range(0, 2047));
         end
      end

      drain_points();
      repeat (16)
         @(posedge clock);

      $display("Run covered %0d start words, %0d point steps, %0d finished circles.",
               start_words, plot_steps, circles_end);
      $display("%0d points checked, %0d mismatches.", checked, mismatches);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
